/* hw/rtl/wmm_pkg.sv */
`default_nettype none

package wmm_pkg;

  // Default store depth; the top level can override it.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int SENDER_W  = 8;
  localparam int KIND_W    = 16;
  localparam int PAYLOAD_W = 64;
  localparam int WANT_S_W  = 9;
  localparam int WANT_K_W  = 17;
  localparam int STATUS_W  = 2;

  localparam int IN_FIELDS_W  = CMD_W + SENDER_W + KIND_W + PAYLOAD_W + WANT_S_W + WANT_K_W;
  localparam int OUT_FIELDS_W = STATUS_W + SENDER_W + KIND_W + PAYLOAD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Wildcard request values (-1)
  localparam logic [WANT_S_W-1:0] WANT_S_ANY = '1;
  localparam logic [WANT_K_W-1:0] WANT_K_ANY = '1;

  // Controller -> datapath
  typedef struct packed {
    logic load;  // capture command, register per-entry match
    logic exec;  // pick, update store, load result register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/wmm_ctrl.sv */
`default_nettype none

module wmm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire wmm_pkg::dp_stat_t  stat,
  output wmm_pkg::ctrl_cmd_t      cmd
);
  import wmm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the result register to drain
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wmm_datapath.sv */
`default_nettype none

module wmm_datapath #(
  parameter int QUEUE_DEPTH = wmm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wmm_pkg::ctrl_cmd_t              cmd,
  output wmm_pkg::dp_stat_t                    stat,
  input  wire logic [wmm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [wmm_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import wmm_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input unpack
  logic [CMD_W-1:0]     in_cmd;
  logic [SENDER_W-1:0]  in_sender;
  logic [KIND_W-1:0]    in_kind;
  logic [PAYLOAD_W-1:0] in_payload;
  logic [WANT_S_W-1:0]  in_want_s;
  logic [WANT_K_W-1:0]  in_want_k;

  assign in_cmd     = in_tdata[1:0];
  assign in_sender  = in_tdata[9:2];
  assign in_kind    = in_tdata[25:10];
  assign in_payload = in_tdata[89:26];
  assign in_want_s  = in_tdata[98:90];
  assign in_want_k  = in_tdata[115:99];

  // Entry cells, oldest at index 0
  logic [SENDER_W-1:0]  sender_r  [QUEUE_DEPTH];
  logic [KIND_W-1:0]    kind_r    [QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0] payload_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]     fill_r, fill_nxt;

  // Captured command
  logic [CMD_W-1:0]       cmd_r;
  logic [SENDER_W-1:0]    new_sender_r;
  logic [KIND_W-1:0]      new_kind_r;
  logic [PAYLOAD_W-1:0]   new_payload_r;
  logic [QUEUE_DEPTH-1:0] match_r, match_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SENDER_W-1:0]  out_sender_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [PAYLOAD_W-1:0] out_payload_r;

  // Per-entry compare against the incoming request
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match_nxt[i] = (CNT_W'(i) < fill_r)
        && ((in_want_s == WANT_S_ANY)
            || (!in_want_s[WANT_S_W-1] && in_want_s[SENDER_W-1:0] == sender_r[i]))
        && ((in_want_k == WANT_K_ANY)
            || (!in_want_k[WANT_K_W-1] && in_want_k[KIND_W-1:0] == kind_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r         <= in_cmd;
      new_sender_r  <= in_sender;
      new_kind_r    <= in_kind;
      new_payload_r <= in_payload;
      match_r       <= match_nxt;
    end
  end

  // Priority pick: first match, and the shift mask from it upward
  logic [QUEUE_DEPTH-1:0] first_vec;
  logic [QUEUE_DEPTH-1:0] shift_vec;
  logic                   hit_any;
  logic [SENDER_W-1:0]    hit_sender;
  logic [KIND_W-1:0]      hit_kind;
  logic [PAYLOAD_W-1:0]   hit_payload;

  always_comb begin
    hit_any     = 1'b0;
    hit_sender  = '0;
    hit_kind    = '0;
    hit_payload = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      first_vec[i] = match_r[i] & ~hit_any;
      hit_any      = hit_any | match_r[i];
      shift_vec[i] = hit_any;
      hit_sender   = hit_sender  | ({SENDER_W{first_vec[i]}}  & sender_r[i]);
      hit_kind     = hit_kind    | ({KIND_W{first_vec[i]}}    & kind_r[i]);
      hit_payload  = hit_payload | ({PAYLOAD_W{first_vec[i]}} & payload_r[i]);
    end
  end

  logic full;
  logic app_ok;
  logic take_ok;
  logic is_lookup;

  assign full      = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign is_lookup = (cmd_r == CMD_PEEK) || (cmd_r == CMD_TAKE);
  assign app_ok    = cmd.exec && (cmd_r == CMD_APPEND) && !full;
  assign take_ok   = cmd.exec && (cmd_r == CMD_TAKE) && hit_any;

  always_comb begin
    fill_nxt = fill_r;
    if (app_ok) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (take_ok) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  // Cell update: compaction on take, tail write on append
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (take_ok && shift_vec[g]) begin
          sender_r[g]  <= sender_r[g+1];
          kind_r[g]    <= kind_r[g+1];
          payload_r[g] <= payload_r[g+1];
        end else if (app_ok && fill_r == CNT_W'(g)) begin
          sender_r[g]  <= new_sender_r;
          kind_r[g]    <= new_kind_r;
          payload_r[g] <= new_payload_r;
        end
      end
    end else begin : g_last
      // the last cell only empties on take; fill count hides it
      always_ff @(posedge clk) begin
        if (app_ok && fill_r == CNT_W'(g)) begin
          sender_r[g]  <= new_sender_r;
          kind_r[g]    <= new_kind_r;
          payload_r[g] <= new_payload_r;
        end
      end
    end
  end

  // Result register
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r  <= ST_DONE;
      out_sender_r  <= '0;
      out_kind_r    <= '0;
      out_payload_r <= '0;
      if (cmd_r == CMD_APPEND && full) begin
        out_status_r <= ST_FULL;
      end else if (is_lookup) begin
        if (hit_any) begin
          out_sender_r  <= hit_sender;
          out_kind_r    <= hit_kind;
          out_payload_r <= hit_payload;
        end else begin
          out_status_r <= ST_NOMATCH;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                       out_payload_r, out_kind_r, out_sender_r, out_status_r};

endmodule

`default_nettype wire

/* hw/rtl/wildcard_match_mailbox_unit.sv */
`default_nettype none

// Ordered mailbox of up to QUEUE_DEPTH messages (sender id, type, 64-bit payload).
// Commands arrive on the in_ stream: append puts a message at the tail (status full
// when the store is at capacity), peek returns the oldest message whose sender and
// type match the request, take returns it and removes it while the rest keep their
// order. A request field of all ones (-1) matches anything; any other negative
// request matches nothing. Every command gives exactly one result transfer on the
// out_ stream; got_* fields are zero unless a message was found. Sequence, when the
// result register is free: the accept cycle registers the per-entry compare of
// the request against every stored message, then the execute state does the
// priority pick of the oldest match, compacts the store on a take and loads the
// result register. A result waiting on out_tready holds the following command
// in its execute state; a new command is accepted while a result waits. The store
// is held in flip-flop cells and tracked by a fill count, so there is no clearing
// pass after reset.
module wildcard_match_mailbox_unit #(
  parameter int QUEUE_DEPTH = wmm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tdata, LSB up: cmd[1:0], new_sender[9:2], new_kind[25:10],
  // new_payload[89:26], want_sender[98:90], want_kind[115:99], zero[119:116]
  input  wire logic [wmm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata, LSB up: status[1:0], got_sender[9:2], got_kind[25:10],
  // got_payload[89:26], zero[95:90]
  output logic [wmm_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import wmm_pkg::*;

  ctrl_cmd_t ctl_cmd;
  dp_stat_t  dp_stat;

  // Handshake and sequencing
  wmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  // Message cells, compare/pick logic, result register
  wmm_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .stat       (dp_stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/wmm_checker.sv */
`default_nettype none

module wmm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [wmm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import wmm_pkg::*;

  // one command in flight: busy the cycle after an accepted transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted back to back");

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // full and no-match results carry no message
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == ST_FULL || out_tdata[1:0] == ST_NOMATCH))
      |-> (out_tdata[OUT_TDATA_W-1:2] == '0))
    else $error("failed command returned message data");

  // status code three is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("illegal status code");

endmodule

bind wildcard_match_mailbox_unit wmm_checker u_wmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
